[rtl/gradient_column_border_detect_assert.svh]
// ----------------------------------------------------------------------------
// Column border detector assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_COLUMN_BORDER_DETECT_ASSERT_SVH
`define GRADIENT_COLUMN_BORDER_DETECT_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define GCBD_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

// The consequent holds at every clock edge at which the antecedent holds.
`define GCBD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[rtl/gcbd_pkg.sv]
// ----------------------------------------------------------------------------
// Column border detector package
// Register codes, reset values, gray weights and the item types.
// ----------------------------------------------------------------------------
package gcbd_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	localparam int CFG_IW = 2;
	localparam int CFG_DW = 11;

	localparam logic [CFG_IW-1:0] REG_EDGE_THRESHOLD = 2'd0;
	localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH    = 2'd1;
	localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT   = 2'd2;

	localparam logic [7:0] THRESHOLD_RST = 8'd30;
	localparam int         WIDTH_RST     = 640;
	localparam int         HEIGHT_RST    = 480;
	localparam int         MIN_SIZE      = 3;

	localparam int GRAY_SUM_W = 23;
	localparam logic [GRAY_SUM_W-1:0] GRAY_KB    = 23'd1868;
	localparam logic [GRAY_SUM_W-1:0] GRAY_KG    = 23'd9617;
	localparam logic [GRAY_SUM_W-1:0] GRAY_KR    = 23'd4899;
	localparam logic [GRAY_SUM_W-1:0] GRAY_ROUND = 23'd8192;
	localparam int GRAY_SHIFT = 14;

	localparam int POS_W = 10;

	typedef struct packed {
		logic       kind;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} in_item_t;

	typedef struct packed {
		logic             mask_bit;
		logic [7:0]       edge_strength;
		logic             is_border;
		logic [POS_W-1:0] out_row;
		logic [POS_W-1:0] out_col;
		logic             last_of_frame;
	} out_item_t;

endpackage

[rtl/gcbd_stream_if.sv]
// ----------------------------------------------------------------------------
// Column border detector stream interface
// Valid/ready channel carrying one item of type T.
// ----------------------------------------------------------------------------
interface gcbd_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/gcbd_ram.sv]
// ----------------------------------------------------------------------------
// Column border detector RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gcbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/gradient_column_border_detect.sv]
// ----------------------------------------------------------------------------
// Gradient column border detector
// Pipeline: an accepted item passes the stage 1, stage 2 and output registers;
// the item that causes a result is the pixel one row plus one pixel later.
// Throughput: one item per cycle unless the output stalls; set by line RAM RMW.
// Reset: arst_n clears positions and control; registers return to threshold
// 30, 640x480. No clearing pass: row 0 of each frame ignores stored flags.
// ----------------------------------------------------------------------------
`include "gradient_column_border_detect_assert.svh"

module gradient_column_border_detect #(
	parameter int MAX_WIDTH  = gcbd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = gcbd_pkg::MAX_HEIGHT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [gcbd_pkg::CFG_IW-1:0] cfg_index,
	input  logic [gcbd_pkg::CFG_DW-1:0] cfg_data,
	gcbd_stream_if.sink                 pix_in,
	gcbd_stream_if.source               res_out
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int W_RST = (gcbd_pkg::WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH
		: gcbd_pkg::WIDTH_RST;
	localparam int H_RST = (gcbd_pkg::HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT
		: gcbd_pkg::HEIGHT_RST;

	typedef struct packed {
		logic [7:0] t;
		logic [7:0] m;
		logic [7:0] b;
	} column_t;

	// Configuration and position state.
	logic [7:0]    thr_q;
	logic [WW-1:0] w_q;
	logic [HW-1:0] h_q;
	logic [RW-1:0] in_row_q;
	logic [CW-1:0] in_col_q;
	logic [RW-1:0] out_row_q;
	logic [CW-1:0] out_col_q;
	logic          draining_q;

	logic          enable;
	logic          accept;
	logic          is_flush;
	logic          start;
	logic          in_col_end;
	logic          in_row_end;
	logic [RW-1:0] cur_or;
	logic [CW-1:0] cur_oc;
	logic          out_col_end;
	logic          out_row_end;
	logic          last;
	logic          pix_emit;
	logic          emit;
	logic          go;
	logic [CW-1:0] vcol;
	logic [CW-1:0] line_raddr;
	logic [RW-1:0] nx_or;
	logic [CW-1:0] nx_oc;
	logic [gcbd_pkg::GRAY_SUM_W-1:0] gray_sum;
	logic [7:0]    gray;
	logic [WW-1:0] w_clamp;
	logic [HW-1:0] h_clamp;

	// Stage 1 registers.
	logic          valid_s1;
	logic          pix_s1;
	logic          emit_s1;
	logic [7:0]    gray_s1;
	logic [CW-1:0] col_s1;
	logic [RW-1:0] r_s1;
	logic [CW-1:0] c_s1;
	logic          last_s1;
	logic          cfirst_s1;
	logic          clast_s1;
	logic          row0_s1;

	// Stage 2 registers.
	logic                valid_s2;
	logic                emit_s2;
	logic signed [10:0]  gx_s2;
	logic signed [10:0]  gy_s2;
	logic                found_s2;
	logic [RW-1:0]       r_s2;
	logic [CW-1:0]       c_s2;
	logic                last_s2;

	logic                out_valid_q;
	gcbd_pkg::out_item_t out_q;

	column_t win0_q;
	column_t win1_q;

	logic [15:0] ln_rdata;
	logic        ln_we;
	logic [15:0] ln_wdata;
	logic        fd_rdata;
	logic        fd_we;

	column_t            new_col;
	column_t            lc;
	column_t            mc;
	column_t            rc;
	logic signed [10:0] gx;
	logic signed [10:0] gy;

	logic [10:0] ax;
	logic [10:0] ay;
	logic [7:0]  sx;
	logic [7:0]  sy;
	logic [8:0]  ssum;
	logic [7:0]  strength;
	logic        border;

	// ---------------------------------------------------------------- stage 0
	assign enable       = !(out_valid_q && !res_out.ready);
	assign pix_in.ready = enable;
	assign accept       = pix_in.valid && enable;
	assign is_flush     = pix_in.data.kind;

	always_comb begin
		start       = (in_row_q == '0) && (in_col_q == '0);
		in_col_end  = (WW'(in_col_q) == (w_q - WW'(1)));
		in_row_end  = (HW'(in_row_q) == (h_q - HW'(1)));
		// A pixel that opens a frame drops whatever was still to be drained.
		cur_or      = (!is_flush && start) ? '0 : out_row_q;
		cur_oc      = (!is_flush && start) ? '0 : out_col_q;
		out_col_end = (WW'(cur_oc) == (w_q - WW'(1)));
		out_row_end = (HW'(cur_or) == (h_q - HW'(1)));
		last        = out_col_end && out_row_end;
		pix_emit    = (in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && (in_col_q != '0));
		emit        = is_flush ? draining_q : pix_emit;
		go          = accept && (!is_flush || draining_q);
		vcol        = out_col_end ? '0 : cur_oc + CW'(1);
		line_raddr  = is_flush ? vcol : in_col_q;
		if (last) begin
			nx_or = '0;
			nx_oc = '0;
		end else if (out_col_end) begin
			nx_or = cur_or + RW'(1);
			nx_oc = '0;
		end else begin
			nx_or = cur_or;
			nx_oc = cur_oc + CW'(1);
		end
	end

	always_comb begin
		gray_sum = gcbd_pkg::GRAY_KB * gcbd_pkg::GRAY_SUM_W'(pix_in.data.blue)
			+ gcbd_pkg::GRAY_KG * gcbd_pkg::GRAY_SUM_W'(pix_in.data.green)
			+ gcbd_pkg::GRAY_KR * gcbd_pkg::GRAY_SUM_W'(pix_in.data.red)
			+ gcbd_pkg::GRAY_ROUND;
		gray = gray_sum[gcbd_pkg::GRAY_SHIFT +: 8];
	end

	always_comb begin
		if (cfg_data < gcbd_pkg::CFG_DW'(gcbd_pkg::MIN_SIZE)) begin
			w_clamp = WW'(gcbd_pkg::MIN_SIZE);
			h_clamp = HW'(gcbd_pkg::MIN_SIZE);
		end else begin
			w_clamp = (32'(cfg_data) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_data);
			h_clamp = (32'(cfg_data) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= gcbd_pkg::THRESHOLD_RST;
			w_q        <= WW'(W_RST);
			h_q        <= HW'(H_RST);
			in_row_q   <= '0;
			in_col_q   <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			draining_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gcbd_pkg::REG_EDGE_THRESHOLD: begin
					thr_q <= cfg_data[7:0];
				end
				gcbd_pkg::REG_FRAME_WIDTH: begin
					w_q        <= w_clamp;
					in_row_q   <= '0;
					in_col_q   <= '0;
					out_row_q  <= '0;
					out_col_q  <= '0;
					draining_q <= 1'b0;
				end
				gcbd_pkg::REG_FRAME_HEIGHT: begin
					h_q        <= h_clamp;
					in_row_q   <= '0;
					in_col_q   <= '0;
					out_row_q  <= '0;
					out_col_q  <= '0;
					draining_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			if (is_flush) begin
				if (draining_q) begin
					out_row_q <= nx_or;
					out_col_q <= nx_oc;
					if (last) begin
						draining_q <= 1'b0;
					end
				end
			end else begin
				if (start) begin
					draining_q <= 1'b0;
					out_row_q  <= '0;
					out_col_q  <= '0;
				end
				if (pix_emit) begin
					out_row_q <= nx_or;
					out_col_q <= nx_oc;
				end
				if (in_col_end) begin
					in_col_q <= '0;
					if (in_row_end) begin
						in_row_q   <= '0;
						draining_q <= 1'b1;
					end else begin
						in_row_q <= in_row_q + RW'(1);
					end
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
			end
		end
	end

	// ------------------------------------------------------------------- RAMs
	// Line RAM entry per column: gray of the previous row above the one before.
	gcbd_ram #(
		.WIDTH (16),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ln_we),
		.waddr (col_s1),
		.wdata (ln_wdata),
		.re    (go),
		.raddr (line_raddr),
		.rdata (ln_rdata)
	);

	// Border-seen flag per column, rewritten on every result of that column.
	gcbd_ram #(
		.WIDTH (1),
		.DEPTH (MAX_WIDTH)
	) u_found_ram (
		.clk   (clk),
		.we    (fd_we),
		.waddr (c_s2),
		.wdata (found_s2 || border),
		.re    (go),
		.raddr (cur_oc),
		.rdata (fd_rdata)
	);

	// ---------------------------------------------------------------- stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (enable) begin
			valid_s1 <= go;
		end
	end

	always_ff @(posedge clk) begin
		if (enable && go) begin
			pix_s1    <= !is_flush;
			emit_s1   <= emit;
			gray_s1   <= gray;
			col_s1    <= in_col_q;
			r_s1      <= cur_or;
			c_s1      <= cur_oc;
			last_s1   <= last;
			cfirst_s1 <= (cur_oc == '0);
			clast_s1  <= out_col_end;
			row0_s1   <= (cur_or == '0);
		end
	end

	assign ln_we    = enable && valid_s1 && pix_s1;
	assign ln_wdata = {gray_s1, ln_rdata[15:8]};

	always_comb begin
		// A flush has no new row, so the top row reflects onto the bottom one.
		new_col.t = ln_rdata[7:0];
		new_col.m = ln_rdata[15:8];
		new_col.b = pix_s1 ? gray_s1 : ln_rdata[7:0];
		if (clast_s1) begin
			lc = win1_q;
			mc = win0_q;
			rc = win1_q;
		end else begin
			lc = cfirst_s1 ? new_col : win1_q;
			mc = win0_q;
			rc = new_col;
		end
		if (row0_s1) begin
			lc.t = lc.b;
			mc.t = mc.b;
			rc.t = rc.b;
		end
		gx = (11'(rc.t) - 11'(lc.t)) + ((11'(rc.m) - 11'(lc.m)) <<< 1)
			+ (11'(rc.b) - 11'(lc.b));
		gy = (11'(lc.b) + (11'(mc.b) <<< 1) + 11'(rc.b))
			- (11'(lc.t) + (11'(mc.t) <<< 1) + 11'(rc.t));
	end

	always_ff @(posedge clk) begin
		if (enable && valid_s1) begin
			win1_q <= win0_q;
			win0_q <= new_col;
		end
	end

	// ---------------------------------------------------------------- stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (enable) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (enable && valid_s1) begin
			emit_s2  <= emit_s1;
			gx_s2    <= gx;
			gy_s2    <= gy;
			found_s2 <= fd_rdata && !row0_s1;
			r_s2     <= r_s1;
			c_s2     <= c_s1;
			last_s2  <= last_s1;
		end
	end

	always_comb begin
		ax       = gx_s2[10] ? 11'(-gx_s2) : 11'(gx_s2);
		ay       = gy_s2[10] ? 11'(-gy_s2) : 11'(gy_s2);
		sx       = (ax > 11'd255) ? 8'd255 : ax[7:0];
		sy       = (ay > 11'd255) ? 8'd255 : ay[7:0];
		ssum     = {1'b0, sx} + {1'b0, sy};
		// Halve, rounding a half up only when that lands on an even value.
		strength = ssum[8:1] + 8'(ssum[0] && ssum[1]);
		border   = !found_s2 && (strength > thr_q);
	end

	assign fd_we = enable && valid_s2 && emit_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (enable) begin
			out_valid_q <= valid_s2 && emit_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (enable && valid_s2 && emit_s2) begin
			out_q.mask_bit      <= found_s2;
			out_q.edge_strength <= strength;
			out_q.is_border     <= border;
			out_q.out_row       <= gcbd_pkg::POS_W'(r_s2);
			out_q.out_col       <= gcbd_pkg::POS_W'(c_s2);
			out_q.last_of_frame <= last_s2;
		end
	end

	assign res_out.valid = out_valid_q;
	assign res_out.data  = out_q;

	// ------------------------------------------------------------- assertions
	`GCBD_ASSERT_IMPLY(a_drain_at_origin, clk, arst_n, draining_q,
		(in_row_q == '0) && (in_col_q == '0), "draining away from frame origin")
	`GCBD_ASSERT_ALWAYS(a_cols_in_frame, clk, arst_n,
		(WW'(in_col_q) < w_q) && (WW'(out_col_q) < w_q), "column beyond frame width")

endmodule

[tb/gradient_column_border_detect_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient column border detector testbench
// Drives BGR pixel and flush items through valid/ready channels with random
// gaps on both sides. Results are checked against an in-bench predictor of the
// gray conversion, Sobel strength and per-column border tracking, or typed ones.
// ----------------------------------------------------------------------------
module gradient_column_border_detect_tb;

	localparam int LIMIT_CYCLES = 2000000;
	localparam int DRAIN_WAIT   = 10;
	localparam int NUM_DIRECTED = 25;
	localparam int RAND_ITEMS   = 650;
	localparam int WIDE_PIXELS  = gcbd_pkg::MAX_WIDTH_DEF + 6;
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;
	localparam logic [gcbd_pkg::CFG_IW-1:0] REG_UNUSED = 2'd3;

	typedef struct {
		gcbd_pkg::in_item_t  item;
		bit                  typed;
		gcbd_pkg::out_item_t res;
	} dir_row_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [gcbd_pkg::CFG_IW-1:0]   cfg_index = '0;
	logic [gcbd_pkg::CFG_DW-1:0]   cfg_data = '0;

	gcbd_stream_if #(.T(gcbd_pkg::in_item_t))  pix_if ();
	gcbd_stream_if #(.T(gcbd_pkg::out_item_t)) res_if ();

	gradient_column_border_detect u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pix_in   (pix_if),
		.res_out  (res_if)
	);

	// Predictor state.
	logic [7:0]  gray_rows [3*gcbd_pkg::MAX_WIDTH_DEF];
	bit          col_seen [gcbd_pkg::MAX_WIDTH_DEF];
	logic [7:0]  thr_q;
	int unsigned width_q, height_q;
	int unsigned in_r, in_c, res_r, res_c;
	bit          drain_on;

	gcbd_pkg::out_item_t pending_res [$];
	int unsigned err_count = 0;
	int unsigned res_count = 0;
	int unsigned border_count = 0;
	int unsigned cycle_count = 0;
	int unsigned rand_items = 0;
	int unsigned frames_sent = 0;
	bit          quiet = 1'b0;
	int unsigned stall_left = 0;
	dir_row_t    dir_tab [NUM_DIRECTED];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		pix_if.valid = 1'b0;
		pix_if.data  = '0;
		res_if.ready = 1'b0;
	end

	function automatic int unsigned gap_len();
		int unsigned p;
		if (quiet) return 0;
		p = $urandom_range(0, 99);
		if (p < 60) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int unsigned used_width();
		if (width_q < gcbd_pkg::MIN_SIZE) return gcbd_pkg::MIN_SIZE;
		if (width_q > gcbd_pkg::MAX_WIDTH_DEF) return gcbd_pkg::MAX_WIDTH_DEF;
		return width_q;
	endfunction

	function automatic int unsigned used_height();
		if (height_q < gcbd_pkg::MIN_SIZE) return gcbd_pkg::MIN_SIZE;
		if (height_q > gcbd_pkg::MAX_HEIGHT_DEF) return gcbd_pkg::MAX_HEIGHT_DEF;
		return height_q;
	endfunction

	function automatic int gray_px(int unsigned row, int unsigned col);
		return int'(gray_rows[(row % 3) * gcbd_pkg::MAX_WIDTH_DEF + col]);
	endfunction

	function automatic int unsigned sat_abs(int v);
		int unsigned a;
		a = (v < 0) ? -v : v;
		return (a > 255) ? 255 : a;
	endfunction

	function automatic void clear_frame();
		in_r = 0; in_c = 0; res_r = 0; res_c = 0;
		drain_on = 1'b0;
		foreach (col_seen[i]) col_seen[i] = 1'b0;
	endfunction

	// Strength and border flags at the current result position, then advance it.
	function automatic gcbd_pkg::out_item_t next_border_result();
		int unsigned w, h, r, c, ru, rd, cl, cr, s, q;
		int a, b, d, e, f, g, k, m, gx, gy;
		bit seen, brd, last;
		gcbd_pkg::out_item_t o;
		w = used_width(); h = used_height();
		r = res_r; c = res_c;
		ru = (r == 0) ? 1 : r - 1;
		rd = (r + 1 >= h) ? h - 2 : r + 1;
		cl = (c == 0) ? 1 : c - 1;
		cr = (c + 1 >= w) ? w - 2 : c + 1;
		a = gray_px(ru, cl); b = gray_px(ru, c); d = gray_px(ru, cr);
		e = gray_px(r, cl); f = gray_px(r, cr);
		g = gray_px(rd, cl); k = gray_px(rd, c); m = gray_px(rd, cr);
		gx = (d - a) + 2 * (f - e) + (m - g);
		gy = (g + 2 * k + m) - (a + 2 * b + d);
		s = sat_abs(gx) + sat_abs(gy);
		q = s >> 1;
		// Round half to even.
		if (s[0] && q[0]) q++;
		seen = col_seen[c];
		brd = !seen && (q > thr_q);
		if (brd) col_seen[c] = 1'b1;
		last = (r == h - 1) && (c == w - 1);
		o.mask_bit      = seen;
		o.edge_strength = q[7:0];
		o.is_border     = brd;
		o.out_row       = r[gcbd_pkg::POS_W-1:0];
		o.out_col       = c[gcbd_pkg::POS_W-1:0];
		o.last_of_frame = last;
		if (last) begin
			res_r = 0; res_c = 0;
		end else if (++res_c >= w) begin
			res_c = 0;
			res_r++;
		end
		return o;
	endfunction

	function automatic bit predict_item(input gcbd_pkg::in_item_t it,
		output gcbd_pkg::out_item_t o);
		int unsigned w, h, gval, n;
		bit hit;
		w = used_width(); h = used_height();
		if (it.kind == KIND_FLUSH) begin
			if (!drain_on) return 1'b0;
			o = next_border_result();
			if (o.last_of_frame) drain_on = 1'b0;
			return 1'b1;
		end
		if (in_r == 0 && in_c == 0) begin
			drain_on = 1'b0;
			res_r = 0; res_c = 0;
			foreach (col_seen[i]) col_seen[i] = 1'b0;
		end
		gval = (1868 * it.blue + 9617 * it.green + 4899 * it.red + 8192) >> 14;
		gray_rows[(in_r % 3) * gcbd_pkg::MAX_WIDTH_DEF + in_c] = gval[7:0];
		n = in_r * w + in_c;
		hit = (n >= w + 1);
		if (++in_c >= w) begin
			in_c = 0;
			if (++in_r >= h) begin
				in_r = 0;
				drain_on = 1'b1;
			end
		end
		if (hit) o = next_border_result();
		return hit;
	endfunction

	// Register write; only issued once the block has gone idle.
	task automatic write_reg(input logic [gcbd_pkg::CFG_IW-1:0] idx, input int unsigned val);
		pix_if.valid <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[gcbd_pkg::CFG_DW-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			gcbd_pkg::REG_EDGE_THRESHOLD: thr_q = val[7:0];
			gcbd_pkg::REG_FRAME_WIDTH: begin
				width_q = 32'(val[gcbd_pkg::CFG_DW-1:0]);
				clear_frame();
			end
			gcbd_pkg::REG_FRAME_HEIGHT: begin
				height_q = 32'(val[gcbd_pkg::CFG_DW-1:0]);
				clear_frame();
			end
			default: ;
		endcase
	endtask

	task automatic send_item(input gcbd_pkg::in_item_t it, input bit typed,
		input gcbd_pkg::out_item_t typed_res);
		int unsigned gap;
		gcbd_pkg::out_item_t o;
		bit hit;
		gap = gap_len();
		if (gap > 0) begin
			pix_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.data  <= it;
		@(posedge clk);
		while (!pix_if.ready) @(posedge clk);
		hit = predict_item(it, o);
		if (hit) pending_res.push_back(typed ? typed_res : o);
	endtask

	task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
		gcbd_pkg::in_item_t it;
		it.kind = KIND_PIXEL; it.blue = b; it.green = g; it.red = r;
		send_item(it, 1'b0, '0);
		rand_items++;
	endtask

	task automatic send_flush();
		gcbd_pkg::in_item_t it;
		it = '0;
		it.kind  = KIND_FLUSH;
		it.blue  = 8'($urandom_range(0, 255));
		it.green = 8'($urandom_range(0, 255));
		it.red   = 8'($urandom_range(0, 255));
		send_item(it, 1'b0, '0);
		rand_items++;
	endtask

	// One frame: either noise or a sky over ground scene, then a drain.
	task automatic send_frame();
		int unsigned w, h, split, nflush;
		logic [7:0] sb, sg, sr, gb, gg, gr;
		bit noisy;
		w = used_width(); h = used_height();
		noisy = ($urandom_range(0, 3) == 0);
		split = $urandom_range(0, h - 1);
		sb = 8'($urandom); sg = 8'($urandom); sr = 8'($urandom);
		gb = 8'($urandom); gg = 8'($urandom); gr = 8'($urandom);
		for (int unsigned y = 0; y < h; y++) begin
			for (int unsigned x = 0; x < w; x++) begin
				if ($urandom_range(0, 49) == 0) send_flush();
				if (noisy)
					send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
				else if (y + ($urandom_range(0, 3) == 0) <= split)
					send_pixel(sb ^ 8'($urandom_range(0, 7)), sg ^ 8'($urandom_range(0, 7)),
						sr ^ 8'($urandom_range(0, 7)));
				else
					send_pixel(gb ^ 8'($urandom_range(0, 7)), gg ^ 8'($urandom_range(0, 7)),
						gr ^ 8'($urandom_range(0, 7)));
			end
		end
		// Mostly a full drain, sometimes a cut one that the next frame drops.
		if ($urandom_range(0, 6) == 0) nflush = $urandom_range(0, w);
		else nflush = w + 1 + $urandom_range(0, 2);
		repeat (nflush) send_flush();
		frames_sent++;
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("gradient_column_border_detect verification failed");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			stall_left   <= 0;
		end else if (stall_left > 0) begin
			res_if.ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else begin
			res_if.ready <= 1'b1;
			stall_left   <= gap_len();
		end
	end

	always @(posedge clk) begin
		gcbd_pkg::out_item_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			res_count++;
			if (res_if.data.is_border) border_count++;
			if (pending_res.size() == 0) begin
				err_count++;
				$display("%0t: unexpected result %p", $time, res_if.data);
			end else begin
				want = pending_res.pop_front();
				if (res_if.data !== want) begin
					err_count++;
					$display("%0t: mismatch expected %p actual %p", $time, want, res_if.data);
				end
			end
		end
	end

	initial begin
		thr_q = gcbd_pkg::THRESHOLD_RST;
		width_q = gcbd_pkg::WIDTH_RST;
		height_q = gcbd_pkg::HEIGHT_RST;
		foreach (gray_rows[i]) gray_rows[i] = '0;
		clear_frame();

		// Directed table: a stray flush, a white 3x3 frame with typed results, its drain,
		// a flush with nothing left, then primary colors, black, white and mixed pixels.
		foreach (dir_tab[i]) begin
			dir_tab[i].item  = '0;
			dir_tab[i].typed = 1'b0;
			dir_tab[i].res   = '0;
		end
		dir_tab[0].item.kind = KIND_FLUSH;
		for (int i = 1; i <= 9; i++) begin
			dir_tab[i].item = '{KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF};
		end
		for (int k = 0; k < 9; k++) begin
			dir_tab[k + 5].typed = 1'b1;
			dir_tab[k + 5].res.out_row = gcbd_pkg::POS_W'(k / 3);
			dir_tab[k + 5].res.out_col = gcbd_pkg::POS_W'(k % 3);
			dir_tab[k + 5].res.last_of_frame = (k == 8);
		end
		for (int i = 10; i <= 14; i++) dir_tab[i].item.kind = KIND_FLUSH;
		dir_tab[15].item = '{KIND_PIXEL, 8'hFF, 8'h00, 8'h00};
		dir_tab[16].item = '{KIND_PIXEL, 8'h00, 8'hFF, 8'h00};
		dir_tab[17].item = '{KIND_PIXEL, 8'h00, 8'h00, 8'hFF};
		dir_tab[18].item = '{KIND_PIXEL, 8'h00, 8'h00, 8'h00};
		dir_tab[19].item = '{KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF};
		dir_tab[20].item = '{KIND_PIXEL, 8'h00, 8'h00, 8'h00};
		dir_tab[21].item = '{KIND_PIXEL, 8'h55, 8'hAA, 8'h55};
		dir_tab[22].item = '{KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF};
		dir_tab[23].item = '{KIND_PIXEL, 8'hAA, 8'h55, 8'hAA};
		dir_tab[24].item.kind = KIND_FLUSH;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(gcbd_pkg::REG_FRAME_WIDTH, 3);
		write_reg(gcbd_pkg::REG_FRAME_HEIGHT, 3);
		foreach (dir_tab[i]) send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].res);

		// Random phases; the frame size writes drop what the directed part left.
		while (rand_items < RAND_ITEMS) begin
			case ($urandom_range(0, 5))
				0: write_reg(gcbd_pkg::REG_EDGE_THRESHOLD, 0);
				1: write_reg(gcbd_pkg::REG_EDGE_THRESHOLD, 255);
				default: write_reg(gcbd_pkg::REG_EDGE_THRESHOLD, $urandom_range(0, 120));
			endcase
			write_reg(gcbd_pkg::REG_FRAME_WIDTH, ($urandom_range(0, 9) == 0) ?
				$urandom_range(13, 40) : $urandom_range(3, 12));
			write_reg(gcbd_pkg::REG_FRAME_HEIGHT, ($urandom_range(0, 9) == 0) ?
				$urandom_range(11, 24) : $urandom_range(3, 10));
			quiet = ($urandom_range(0, 4) == 0);
			repeat ($urandom_range(1, 3)) begin
				if (rand_items < RAND_ITEMS) send_frame();
			end
		end
		quiet = 1'b0;

		// Out of range sizes clamp to the minimum and the maximum.
		write_reg(REG_UNUSED, 2047);
		write_reg(gcbd_pkg::REG_EDGE_THRESHOLD, 0);
		write_reg(gcbd_pkg::REG_FRAME_WIDTH, 0);
		write_reg(gcbd_pkg::REG_FRAME_HEIGHT, 1);
		send_frame();
		write_reg(gcbd_pkg::REG_EDGE_THRESHOLD, 255);
		write_reg(gcbd_pkg::REG_FRAME_WIDTH, 2047);
		write_reg(gcbd_pkg::REG_FRAME_HEIGHT, 2047);
		// A full-width first row and a few pixels more give the first results.
		for (int i = 0; i < WIDE_PIXELS; i++) begin
			send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
		end

		pix_if.valid <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Sent %0d frames and %0d random items; checked %0d results, %0d borders.",
			frames_sent, rand_items, res_count, border_count);
		$display("Thresholds 0 to 255, clamped minimum frames and a clamped maximum row ran.");
		if (err_count == 0)
			$display("gradient_column_border_detect verification clean");
		else
			$display("gradient_column_border_detect verification failed");
		$finish;
	end

endmodule
